>>> rtl/rhc_pkg.sv
// Shared types and constants for the RGB to HSL converter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rhc_pkg;

    // Number of fraction bits of the saturation result.
    localparam int SAT_FRAC_BITS = 15;

    // One quotient bit per division cell; the saturation quotient sets the count.
    localparam int DIV_STEPS = SAT_FRAC_BITS + 1;

    // Remainder plus remaining dividend and quotient bits of one division.
    localparam int DIV_W = 8 + DIV_STEPS;

    // Width that holds the raw saturation quotient and the 16-bit clamp value.
    localparam int SAT_Q_W = (DIV_STEPS > 16) ? DIV_STEPS : 16;

    // Hue numerator magnitude: 60 times at most 1275 fits in 17 bits.
    localparam int HUE_NUM_W = 17;
    localparam int HUE_SCALE = 60;
    localparam int HUE_WRAP  = 360;

    // Largest value that the 16-bit saturation field can carry.
    localparam logic [15:0] SAT_MAX = 16'hFFFF;

    // Input pixel.
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pixel;

    // Output color.
    typedef struct packed {
        logic [8:0]  hue_deg;
        logic [15:0] sat_frac;
        logic [8:0]  light_sum;
    } t_hsl;

    // Work carried from cell to cell: two restoring divisions side by side.
    typedef struct packed {
        logic [7:0]           rem_h;
        logic [DIV_STEPS-1:0] acc_h;
        logic [7:0]           div_h;
        logic [7:0]           rem_s;
        logic [DIV_STEPS-1:0] acc_s;
        logic [8:0]           div_s;
        logic                 hue_neg;
        logic                 grey;
        logic [8:0]           light_sum;
    } t_cell_data;

    // One stage's output toward its downstream neighbor.
    typedef struct packed {
        logic       valid;
        t_cell_data data;
    } t_stage;

endpackage

`default_nettype wire

>>> rtl/rhc_front.sv
// Front stage: finds max and min, forms both dividends and divisors.
// Depends on rhc_pkg.
`default_nettype none

module rhc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire rhc_pkg::t_pixel i_pixel,
    input  wire logic            i_hold,
    output rhc_pkg::t_stage      o_stage,
    output logic                 o_hold
);

    logic                    r_valid;
    rhc_pkg::t_cell_data     r_data;
    rhc_pkg::t_cell_data     n_data;

    logic [7:0]              red;
    logic [7:0]              green;
    logic [7:0]              blue;
    logic                    red_max;
    logic                    green_max;
    logic [7:0]              mx;
    logic [7:0]              mn;
    logic [7:0]              diff;
    logic signed [11:0]      hue_t;
    logic [11:0]             hue_mag;
    logic [rhc_pkg::HUE_NUM_W-1:0] hue_num;
    logic [rhc_pkg::DIV_W-1:0] hue_pair;
    logic [rhc_pkg::DIV_W-1:0] sat_pair;
    logic [8:0]              sum;
    logic [8:0]              den;

    // Channel ordering; red wins ties over green, green over blue.
    always_comb begin
        red       = i_pixel.red_in;
        green     = i_pixel.green_in;
        blue      = i_pixel.blue_in;
        red_max   = (red >= green) && (red >= blue);
        green_max = !red_max && (green >= blue);
        priority if (red_max) begin
            mx = red;
        end else if (green_max) begin
            mx = green;
        end else begin
            mx = blue;
        end
        if ((red <= green) && (red <= blue)) begin
            mn = red;
        end else if (green <= blue) begin
            mn = green;
        end else begin
            mn = blue;
        end
        diff = mx - mn;
    end

    // Hue numerator in sixths of the circle, then its magnitude times 60.
    always_comb begin
        priority if (red_max) begin
            hue_t = $signed({4'b0000, green}) - $signed({4'b0000, blue});
        end else if (green_max) begin
            hue_t = $signed({3'b000, diff, 1'b0}) + $signed({4'b0000, blue})
                  - $signed({4'b0000, red});
        end else begin
            hue_t = $signed({2'b00, diff, 2'b00}) + $signed({4'b0000, red})
                  - $signed({4'b0000, green});
        end
        hue_mag  = hue_t[11] ? 12'(-hue_t) : 12'(hue_t);
        hue_num  = rhc_pkg::HUE_NUM_W'(hue_mag) * rhc_pkg::HUE_NUM_W'(rhc_pkg::HUE_SCALE);
        hue_pair = rhc_pkg::DIV_W'(hue_num);
    end

    // Lightness sum and saturation divisor 256 - |sum - 256|.
    always_comb begin
        sum = {1'b0, mx} + {1'b0, mn};
        if (sum[8]) begin
            den = 9'(10'd512 - {1'b0, sum});
        end else begin
            den = sum;
        end
        sat_pair = rhc_pkg::DIV_W'(diff) << rhc_pkg::SAT_FRAC_BITS;
    end

    // Pack the first cell's input.
    always_comb begin
        n_data.rem_h     = hue_pair[rhc_pkg::DIV_W-1:rhc_pkg::DIV_STEPS];
        n_data.acc_h     = hue_pair[rhc_pkg::DIV_STEPS-1:0];
        n_data.div_h     = diff;
        n_data.rem_s     = sat_pair[rhc_pkg::DIV_W-1:rhc_pkg::DIV_STEPS];
        n_data.acc_s     = sat_pair[rhc_pkg::DIV_STEPS-1:0];
        n_data.div_s     = den;
        n_data.hue_neg   = hue_t[11];
        n_data.grey      = (mx == mn);
        n_data.light_sum = sum;
    end

    // The stage holds only while it is full and its neighbor holds.
    assign o_hold = r_valid & i_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_hold) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_hold && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

endmodule

`default_nettype wire

>>> rtl/rhc_cell.sv
// Division cell: one restoring step for the hue and the saturation quotient.
// Depends on rhc_pkg.
`default_nettype none

module rhc_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rhc_pkg::t_stage i_stage,
    input  wire logic            i_hold,
    output rhc_pkg::t_stage      o_stage,
    output logic                 o_hold
);

    logic                r_valid;
    rhc_pkg::t_cell_data r_data;
    rhc_pkg::t_cell_data n_data;

    logic [8:0] trial_h;
    logic [8:0] trial_s;
    logic       ge_h;
    logic       ge_s;

    // Shift the next dividend bit into each remainder and try the subtract.
    always_comb begin
        n_data  = i_stage.data;
        trial_h = {i_stage.data.rem_h, i_stage.data.acc_h[rhc_pkg::DIV_STEPS-1]};
        trial_s = {i_stage.data.rem_s, i_stage.data.acc_s[rhc_pkg::DIV_STEPS-1]};
        ge_h    = trial_h >= {1'b0, i_stage.data.div_h};
        ge_s    = trial_s >= i_stage.data.div_s;
        n_data.rem_h = ge_h ? 8'(trial_h - {1'b0, i_stage.data.div_h}) : trial_h[7:0];
        n_data.rem_s = ge_s ? 8'(trial_s - i_stage.data.div_s) : trial_s[7:0];
        n_data.acc_h = {i_stage.data.acc_h[rhc_pkg::DIV_STEPS-2:0], ge_h};
        n_data.acc_s = {i_stage.data.acc_s[rhc_pkg::DIV_STEPS-2:0], ge_s};
    end

    assign o_hold = r_valid & i_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_hold) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_hold && i_stage.valid) begin
            r_data <= n_data;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

    // Each partial remainder stays below its divisor for a colored pixel.
    a_hue_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_data.grey |-> r_data.rem_h < r_data.div_h)
        else $error("hue remainder not below divisor");

    a_sat_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_data.grey |-> {1'b0, r_data.rem_s} < r_data.div_s)
        else $error("saturation remainder not below divisor");

endmodule

`default_nettype wire

>>> rtl/rhc_back.sv
// Output stage: hue sign fix and wrap, saturation clamp, output register.
// Depends on rhc_pkg.
`default_nettype none

module rhc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rhc_pkg::t_stage i_stage,
    input  wire logic            i_stall,
    output logic                 o_hold,
    output logic                 o_out_valid,
    output rhc_pkg::t_hsl        o_out_data
);

    logic                       r_valid;
    rhc_pkg::t_hsl              r_data;
    rhc_pkg::t_hsl              n_data;
    logic [8:0]                 hue_q;
    logic [rhc_pkg::SAT_Q_W-1:0] sat_q;

    // Truncation toward zero was done on the magnitude; negative hues wrap.
    always_comb begin
        hue_q = i_stage.data.acc_h[8:0];
        sat_q = rhc_pkg::SAT_Q_W'(i_stage.data.acc_s);
        if (i_stage.data.grey) begin
            n_data.hue_deg = 9'd0;
        end else if (i_stage.data.hue_neg && (hue_q != 9'd0)) begin
            n_data.hue_deg = 9'(rhc_pkg::HUE_WRAP) - hue_q;
        end else begin
            n_data.hue_deg = hue_q;
        end
        if (i_stage.data.grey) begin
            n_data.sat_frac = 16'd0;
        end else if (sat_q > rhc_pkg::SAT_Q_W'(rhc_pkg::SAT_MAX)) begin
            n_data.sat_frac = rhc_pkg::SAT_MAX;
        end else begin
            n_data.sat_frac = sat_q[15:0];
        end
        n_data.light_sum = i_stage.data.light_sum;
    end

    assign o_hold = r_valid & i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_hold) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_hold && i_stage.valid) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    // Hue always lands inside one turn.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_data.hue_deg < 9'(rhc_pkg::HUE_WRAP))
        else $error("hue out of range");

    // The divider never yields more than one whole unit of saturation.
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stage.valid && !i_stage.data.grey |->
            rhc_pkg::SAT_Q_W'(i_stage.data.acc_s)
            <= rhc_pkg::SAT_Q_W'(64'd1 << rhc_pkg::SAT_FRAC_BITS))
        else $error("saturation quotient above one");

endmodule

`default_nettype wire

>>> rtl/rgb_to_hsl_converter_unit.sv
// RGB to HSL converter top level: front stage, division cell chain, output stage.
// Depends on rhc_pkg, rhc_front, rhc_cell and rhc_back.
//
// Usage:
// The input channel takes one 8-bit RGB pixel per transaction (i_in_valid,
// i_in_data, o_in_stall); the output channel gives hue in degrees, saturation
// in Q1.15 and the max plus min lightness sum (o_out_valid, o_out_data,
// i_out_stall). Every pixel yields exactly one result, in order.
// The pipeline is one front stage, one division cell per quotient bit, and
// the output register. Throughput is one pixel per cycle while the receiver
// does not stall; the chain of division cells, each producing one hue and
// one saturation quotient bit, sets the latency.
// When the receiver stalls, the output register holds its transaction and
// each stage holds only while its downstream neighbor holds, so empty stages
// keep filling and new pixels are taken until the whole chain is full.
// Synchronous reset empties every stage; no result is pending after reset.
`default_nettype none

module rgb_to_hsl_converter_unit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire rhc_pkg::t_pixel i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output rhc_pkg::t_hsl        o_out_data,
    input  wire logic            i_out_stall
);

    rhc_pkg::t_stage                link [rhc_pkg::DIV_STEPS+1];
    logic [rhc_pkg::DIV_STEPS:0]    hold;

    // Operand preparation.
    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_pixel (i_in_data),
        .i_hold  (hold[0]),
        .o_stage (link[0]),
        .o_hold  (o_in_stall)
    );

    // One restoring division cell per quotient bit.
    for (genvar gi = 0; gi < rhc_pkg::DIV_STEPS; gi++) begin : g_cell
        rhc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (link[gi]),
            .i_hold  (hold[gi+1]),
            .o_stage (link[gi+1]),
            .o_hold  (hold[gi])
        );
    end

    // Result fix-up and output register.
    rhc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (link[rhc_pkg::DIV_STEPS]),
        .i_stall     (i_out_stall),
        .o_hold      (hold[rhc_pkg::DIV_STEPS]),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the RGB to HSL converter, driving pixels and checking each color.
// Depends on rhc_pkg and the rgb_to_hsl_converter_unit RTL; needs no other files.
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_HALF_NS  = 4;
    localparam int RESET_CYCLES = 11;
    localparam int PIX_SPAN     = 256;
    localparam int MAX_GAP      = 17;
    localparam int HOLD_CYCLES  = 300;
    localparam int LATENCY      = rhc_pkg::DIV_STEPS + 2;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 2000;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            in_valid    = 1'b0;
    rhc_pkg::t_pixel in_pixel    = '0;
    logic            out_stall   = 1'b0;
    logic            o_in_stall;
    logic            o_out_valid;
    rhc_pkg::t_hsl   o_out_data;

    // Colors predicted for accepted pixels, oldest first.
    rhc_pkg::t_hsl   hsl_pending[$];
    int              mismatch_count = 0;
    bit              tx_idle = 1'b1;
    bit              rx_idle = 1'b1;
    bit              hold_request = 1'b0;

    rgb_to_hsl_converter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_pixel),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Exact integer hue, saturation and lightness of one pixel.
    function automatic rhc_pkg::t_hsl hsl_of_pixel(input rhc_pkg::t_pixel px);
        int            r, g, b, mx, mn, d, n, a, c, num, h, s, dev;
        longint        q;
        rhc_pkg::t_hsl res;
        r = px.red_in;
        g = px.green_in;
        b = px.blue_in;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        h = 0;
        // Red wins ties for maximum over green, and green over blue.
        if (d != 0) begin
            if (mx == r) begin
                n = 0; a = g; c = b;
            end else if (mx == g) begin
                n = 2; a = b; c = r;
            end else begin
                n = 4; a = r; c = g;
            end
            num = rhc_pkg::HUE_SCALE * n * d + rhc_pkg::HUE_SCALE * (a - c);
            h = (num >= 0) ? num / d : -((-num) / d);
            if (h < 0) h += rhc_pkg::HUE_WRAP;
        end
        // Saturation divides by 256 less the distance of max plus min from 256.
        s = mx + mn;
        dev = (s >= PIX_SPAN) ? s - PIX_SPAN : PIX_SPAN - s;
        q = 0;
        if (d != 0 && dev < PIX_SPAN) begin
            q = (longint'(d) << rhc_pkg::SAT_FRAC_BITS) / (PIX_SPAN - dev);
            if (q > longint'(rhc_pkg::SAT_MAX)) q = rhc_pkg::SAT_MAX;
        end
        res.hue_deg   = h[8:0];
        res.sat_frac  = q[15:0];
        res.light_sum = s[8:0];
        return res;
    endfunction

    function automatic int draw_gap(input bit idle_on);
        return idle_on ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    function automatic rhc_pkg::t_pixel make_pixel(input int r, input int g, input int b);
        rhc_pkg::t_pixel px;
        px.red_in   = r[7:0];
        px.green_in = g[7:0];
        px.blue_in  = b[7:0];
        return px;
    endfunction

    // Random pixel: mostly full range, with greys, ties and channel extremes mixed in.
    function automatic rhc_pkg::t_pixel draw_pixel();
        int kind, v, w, pick;
        int ends[4];
        ends = '{0, 1, 254, 255};
        kind = $urandom_range(0, 9);
        v = $urandom_range(0, 255);
        w = $urandom_range(0, v);
        pick = $urandom_range(0, 2);
        case (kind)
            0: return make_pixel(v, v, v);
            1: begin
                if (pick == 0) return make_pixel(v, v, w);
                else if (pick == 1) return make_pixel(w, v, v);
                else return make_pixel(v, w, v);
            end
            2: return make_pixel(ends[$urandom_range(0, 3)], ends[$urandom_range(0, 3)],
                                 ends[$urandom_range(0, 3)]);
            default: return make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                                       $urandom_range(0, 255));
        endcase
    endfunction

    // Offer one pixel after an idle gap and hold it until the transaction completes.
    task automatic send_pixel(input rhc_pkg::t_pixel px);
        int  gap;
        bit  stalled;
        gap = draw_gap(tx_idle);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_pixel <= px;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        hsl_pending.push_back(hsl_of_pixel(px));
    endtask

    // Receiver: stalls at random, honors a long hold-off, and checks each result.
    initial begin : result_checker
        int            gap;
        bit            seen;
        rhc_pkg::t_hsl got, want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0) rx_idle = !rx_idle;
            gap = draw_gap(rx_idle);
            if (hold_request) begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                out_stall <= 1'b0;
            end
            do begin
                @(negedge i_clk);
                seen = o_out_valid;
                got  = o_out_data;
                @(posedge i_clk);
            end while (!seen);
            if (hsl_pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual hue %0d sat %0d light %0d",
                         $time, got.hue_deg, got.sat_frac, got.light_sum);
                mismatch_count++;
            end else begin
                want = hsl_pending.pop_front();
                if (got.hue_deg !== want.hue_deg) begin
                    $display("%0t: hue_deg mismatch, expected %0d actual %0d",
                             $time, want.hue_deg, got.hue_deg);
                    mismatch_count++;
                end
                if (got.sat_frac !== want.sat_frac) begin
                    $display("%0t: sat_frac mismatch, expected %0d actual %0d",
                             $time, want.sat_frac, got.sat_frac);
                    mismatch_count++;
                end
                if (got.light_sum !== want.light_sum) begin
                    $display("%0t: light_sum mismatch, expected %0d actual %0d",
                             $time, want.light_sum, got.light_sum);
                    mismatch_count++;
                end
            end
        end
    end

    // Greys, primaries, ties, negative hue wrap and channel extremes.
    task automatic test_directed();
        send_pixel(make_pixel(0, 0, 0));
        send_pixel(make_pixel(255, 255, 255));
        send_pixel(make_pixel(128, 128, 128));
        send_pixel(make_pixel(255, 0, 0));
        send_pixel(make_pixel(0, 255, 0));
        send_pixel(make_pixel(0, 0, 255));
        send_pixel(make_pixel(255, 255, 0));
        send_pixel(make_pixel(0, 255, 255));
        send_pixel(make_pixel(255, 0, 255));
        send_pixel(make_pixel(255, 0, 1));
        send_pixel(make_pixel(255, 0, 128));
        send_pixel(make_pixel(1, 0, 0));
        send_pixel(make_pixel(0, 1, 0));
        send_pixel(make_pixel(0, 0, 1));
        send_pixel(make_pixel(255, 254, 254));
        send_pixel(make_pixel(254, 255, 255));
        send_pixel(make_pixel(255, 255, 254));
        send_pixel(make_pixel(170, 85, 170));
        send_pixel(make_pixel(85, 170, 85));
        send_pixel(make_pixel(200, 100, 50));
        send_pixel(make_pixel(10, 240, 128));
        send_pixel(make_pixel(127, 129, 128));
        send_pixel(make_pixel(254, 0, 255));
        send_pixel(make_pixel(200, 1, 255));
    endtask

    // Random pixels with the sender switching between idling and streaming.
    task automatic test_random();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 63) == 0) tx_idle = !tx_idle;
            send_pixel(draw_pixel());
        end
    endtask

    // A long receiver hold-off while pixels keep coming, so the chain fills and stalls.
    task automatic test_backpressure();
        tx_idle = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 4 * LATENCY; i++) send_pixel(draw_pixel());
        tx_idle = 1'b1;
    endtask

    // Drain every pending result, let the pipeline settle, then report.
    task automatic finish_run();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (hsl_pending.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * LATENCY) @(posedge i_clk);
        if (hsl_pending.size() != 0) begin
            $display("%0t: %0d results never arrived, expected 0 pending, actual %0d",
                     $time, hsl_pending.size(), hsl_pending.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    endtask

    // Reset once, then run the tests in turn.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random();
        test_backpressure();
        finish_run();
    end

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> rgb_to_hsl_converter_unit.f
rtl/rhc_pkg.sv
rtl/rhc_front.sv
rtl/rhc_cell.sv
rtl/rhc_back.sv
rtl/rgb_to_hsl_converter_unit.sv
tb/sv/tb_top.sv
